// ===== src/bimodal_histogram_threshold_core_macros.svh =====
// Assertion macros for the bimodal histogram threshold core.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BIMODAL_HISTOGRAM_THRESHOLD_CORE_MACROS_SVH
`define BIMODAL_HISTOGRAM_THRESHOLD_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bht check failed");

// Next-cycle implication, checked out of reset
`define BHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bht check failed");

`endif

// ===== src/bht_pkg.sv =====
// Shared constants, command/status types and codes of the histogram threshold core.
// No dependencies.
`default_nettype none
package bht_pkg;
    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = $clog2(BIN_COUNT);
    localparam int TOP_BIN    = BIN_COUNT - 1;
    localparam int PIX_W      = 8;
    localparam int PK_W       = 9;
    localparam int SUM_W      = COUNT_BITS + 2;
    localparam int DIV3_SH    = SUM_W + 1;
    localparam logic [63:0] DIV3_MUL_L = ((64'd1 << DIV3_SH) + 64'd2) / 64'd3;
    localparam logic [DIV3_SH-1:0] DIV3_MUL = DIV3_MUL_L[DIV3_SH-1:0];
    localparam int W_W        = COUNT_BITS + IDX_W + 1;
    localparam logic [PK_W-1:0] BIN_END = PK_W'(BIN_COUNT);
    localparam logic [PIX_W-1:0] GRAY_MAX = 8'd255;
    localparam logic [PIX_W-1:0] SPACING_RST = 8'd10;
    localparam logic TECH_MID = 1'b0;
    localparam logic REG_TECH = 1'b0;
    localparam logic REG_SPACE = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_SMOOTH = 3'd2,
        OP_PEAK2  = 3'd3,
        OP_VINIT  = 3'd4,
        OP_VSCAN  = 3'd5,
        OP_WEIGH  = 3'd6
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [PK_W-1:0] addr;
        logic            init;
        logic            set_mid;
        logic            set_valley;
        logic            load_out;
        logic            pix_en;
    } t_dp_cmd;

    typedef struct packed {
        logic             busy;
        logic             out_full;
        logic             last_acc;
        logic [PIX_W-1:0] p_lo;
        logic [PIX_W-1:0] p_hi;
    } t_dp_sts;

    typedef struct packed {
        logic             tech;
        logic [PIX_W-1:0] space;
    } t_cfg;
endpackage
`default_nettype wire

// ===== src/bht_if.sv =====
// Pixel and result channel interfaces with valid/ready handshake.
// Depends on bht_pkg.
`default_nettype none
interface bht_pix_if;
    import bht_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] gray_level;
    logic             frame_last;
    modport source (output valid, output gray_level, output frame_last, input ready);
    modport sink (input valid, input gray_level, input frame_last, output ready);
endinterface

interface bht_res_if;
    import bht_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] lower_bound;
    logic [PIX_W-1:0] upper_bound;
    logic [PIX_W-1:0] peak_one;
    logic [PIX_W-1:0] peak_two;
    logic [PIX_W-1:0] split_level;
    modport source (output valid, output lower_bound, output upper_bound,
                    output peak_one, output peak_two, output split_level, input ready);
    modport sink (input valid, input lower_bound, input upper_bound,
                  input peak_one, input peak_two, input split_level, output ready);
endinterface
`default_nettype wire

// ===== src/bht_dp.sv =====
// Datapath: bin and smoothed-bin memories, smoothing pipeline, scan accumulators, result register.
// Depends on bht_pkg and bht_if.
`default_nettype none
module bht_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bht_pkg::t_cfg  i_cfg,
    input  wire bht_pkg::t_dp_cmd i_cmd,
    output bht_pkg::t_dp_sts    o_sts,
    bht_pix_if.sink             i_pix,
    bht_res_if.source           o_res
);
    import bht_pkg::*;

    logic [COUNT_BITS-1:0] r_bins [BIN_COUNT];
    logic [COUNT_BITS-1:0] r_sm   [BIN_COUNT];

    // collect path
    logic                  pix_acc;
    logic [IDX_W-1:0]      pix_bin;
    logic                  r_c_valid;
    logic [IDX_W-1:0]      r_c_addr;
    logic                  r_fw_valid;
    logic [IDX_W-1:0]      r_fw_addr;
    logic [COUNT_BITS-1:0] r_fw_data;
    logic [COUNT_BITS-1:0] inc_val;
    logic [COUNT_BITS-1:0] r_bin_q;

    // bin memory port
    logic                  bin_we;
    logic [IDX_W-1:0]      bin_wa;
    logic [COUNT_BITS-1:0] bin_wd;
    logic [IDX_W-1:0]      bin_ra;

    // smoothing pipeline
    logic                  r_s1_valid;
    logic [PK_W-1:0]       r_s1_idx;
    logic [COUNT_BITS-1:0] s1_cur;
    logic [COUNT_BITS-1:0] r_w1;
    logic [COUNT_BITS-1:0] r_w2;
    logic                  r_s2_valid;
    logic                  r_s2_half;
    logic [SUM_W-1:0]      r_s2_sum;
    logic [IDX_W-1:0]      r_s2_idx;
    logic                  r_s3_valid;
    logic [COUNT_BITS-1:0] r_s3_val;
    logic [IDX_W-1:0]      r_s3_idx;
    logic [SUM_W+DIV3_SH-1:0] div_prod;

    // scan path
    logic                  r_q_valid;
    t_op                   r_q_op;
    logic [PK_W-1:0]       r_q_idx;
    logic [COUNT_BITS-1:0] r_sq;
    logic [COUNT_BITS-1:0] q_val;
    logic                  sm_rd;

    // accumulators
    logic                  r_p1_found;
    logic [PIX_W-1:0]      r_p1_idx;
    logic [COUNT_BITS-1:0] r_p1_val;
    logic                  r_p2_found;
    logic [PIX_W-1:0]      r_p2_idx;
    logic [COUNT_BITS-1:0] r_p2_val;
    logic [PIX_W-1:0]      r_v_idx;
    logic [COUNT_BITS-1:0] r_v_val;
    logic [W_W-1:0]        r_below;
    logic [W_W-1:0]        r_above;
    logic [PIX_W-1:0]      r_split;
    logic [PIX_W-1:0]      p1;
    logic [PIX_W-1:0]      p2;
    logic [PK_W-1:0]       best9;
    logic [PK_W-1:0]       peak_gap;
    logic [PK_W-1:0]       mid_sum;

    // output register
    logic                  r_out_valid;
    logic [PIX_W-1:0]      r_lower;
    logic [PIX_W-1:0]      r_upper;
    logic [PIX_W-1:0]      r_o_p1;
    logic [PIX_W-1:0]      r_o_p2;
    logic [PIX_W-1:0]      r_o_split;

    // map gray to bin, top bin takes the overflow
    assign pix_acc = i_pix.valid && i_cmd.pix_en;
    assign pix_bin = ({1'b0, i_pix.gray_level} < BIN_END) ?
                     i_pix.gray_level[IDX_W-1:0] : IDX_W'(TOP_BIN);
    assign i_pix.ready = i_cmd.pix_en;

    // increment with forwarding of the previous beat's write
    assign inc_val = ((r_fw_valid && (r_fw_addr == r_c_addr)) ? r_fw_data : r_bin_q) +
                     COUNT_BITS'(1);

    always_comb begin
        bin_we = 1'b0;
        bin_wa = r_c_addr;
        bin_wd = inc_val;
        bin_ra = pix_bin;
        if (r_c_valid) begin
            bin_we = 1'b1;
        end else if ((i_cmd.op == OP_CLEAR) || (i_cmd.op == OP_SMOOTH)) begin
            bin_we = (i_cmd.addr < BIN_END);
            bin_wa = i_cmd.addr[IDX_W-1:0];
            bin_wd = '0;
        end
        if (i_cmd.op == OP_SMOOTH) begin
            bin_ra = i_cmd.addr[IDX_W-1:0];
        end
    end

    // bin memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            r_bins[bin_wa] <= bin_wd;
        end
        r_bin_q <= r_bins[bin_ra];
    end

    always_ff @(posedge i_clk) begin
        r_c_addr  <= pix_bin;
        r_fw_addr <= r_c_addr;
        r_fw_data <= inc_val;
    end

    // smoothing stage 1: sliding window and sums
    assign s1_cur = (r_s1_idx < BIN_END) ? r_bin_q : '0;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_w1 <= s1_cur;
            r_w2 <= r_w1;
            r_s2_idx <= IDX_W'(r_s1_idx - PK_W'(1));
            if (r_s1_idx == PK_W'(1)) begin
                r_s2_half <= 1'b1;
                r_s2_sum  <= SUM_W'(r_w1) + SUM_W'(s1_cur);
            end else if (r_s1_idx == BIN_END) begin
                r_s2_half <= 1'b1;
                r_s2_sum  <= SUM_W'(r_w2) + SUM_W'(r_w1);
            end else begin
                r_s2_half <= 1'b0;
                r_s2_sum  <= SUM_W'(r_w2) + SUM_W'(r_w1) + SUM_W'(s1_cur);
            end
        end
    end

    // smoothing stage 2: halve or divide by three through the reciprocal
    assign div_prod = (SUM_W+DIV3_SH)'(r_s2_sum) * (SUM_W+DIV3_SH)'(DIV3_MUL);

    always_ff @(posedge i_clk) begin
        r_s3_idx <= r_s2_idx;
        if (r_s2_half) begin
            r_s3_val <= COUNT_BITS'(r_s2_sum >> 1);
        end else begin
            r_s3_val <= COUNT_BITS'(div_prod >> DIV3_SH);
        end
    end

    // smoothed memory: write from stage 3, registered read for scans
    assign sm_rd = (i_cmd.op == OP_PEAK2) || (i_cmd.op == OP_VINIT) ||
                   (i_cmd.op == OP_VSCAN) || (i_cmd.op == OP_WEIGH);

    always_ff @(posedge i_clk) begin
        if (r_s3_valid) begin
            r_sm[r_s3_idx] <= r_s3_val;
        end
        r_sq <= r_sm[i_cmd.addr[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_q_op  <= i_cmd.op;
        r_q_idx <= i_cmd.addr;
    end

    // bins beyond the table read as zero
    assign q_val = (r_q_idx < BIN_END) ? r_sq : '0;

    assign p1       = r_p1_found ? r_p1_idx : '0;
    assign p2       = r_p2_found ? r_p2_idx : '0;
    assign best9    = r_p1_found ? {1'b0, r_p1_idx} : 9'd256;
    assign peak_gap = (best9 > r_q_idx) ? (best9 - r_q_idx) : (r_q_idx - best9);
    assign mid_sum  = {1'b0, p1} + {1'b0, p2};

    // peak, valley and weight accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_found <= 1'b0;
            r_p2_found <= 1'b0;
        end else if (i_cmd.init) begin
            r_p1_found <= 1'b0;
            r_p2_found <= 1'b0;
            r_p1_val   <= '0;
            r_p2_val   <= '0;
            r_below    <= '0;
            r_above    <= '0;
        end else begin
            if (r_s3_valid && (r_s3_val > r_p1_val)) begin
                r_p1_found <= 1'b1;
                r_p1_idx   <= PIX_W'(r_s3_idx);
                r_p1_val   <= r_s3_val;
            end
            if (r_q_valid) begin
                case (r_q_op)
                    OP_PEAK2: begin
                        if ((q_val > r_p2_val) && (peak_gap > {1'b0, i_cfg.space})) begin
                            r_p2_found <= 1'b1;
                            r_p2_idx   <= r_q_idx[PIX_W-1:0];
                            r_p2_val   <= q_val;
                        end
                    end
                    OP_VINIT: begin
                        r_v_idx <= r_q_idx[PIX_W-1:0];
                        r_v_val <= q_val;
                    end
                    OP_VSCAN: begin
                        if (r_v_val > q_val) begin
                            r_v_idx <= r_q_idx[PIX_W-1:0];
                            r_v_val <= q_val;
                        end
                    end
                    OP_WEIGH: begin
                        if (r_q_idx < {1'b0, r_split}) begin
                            r_below <= r_below + W_W'(q_val);
                        end else begin
                            r_above <= r_above + W_W'(q_val);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // split point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= '0;
        end else if (i_cmd.set_mid) begin
            r_split <= mid_sum[PK_W-1:1];
        end else if (i_cmd.set_valley) begin
            r_split <= r_v_idx;
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_q_valid  <= 1'b0;
        end else begin
            r_c_valid  <= pix_acc;
            r_fw_valid <= r_c_valid;
            r_s1_valid <= (i_cmd.op == OP_SMOOTH);
            r_s2_valid <= r_s1_valid && (r_s1_idx != '0);
            r_s3_valid <= r_s2_valid;
            r_q_valid  <= sm_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= i_cmd.addr;
    end

    // result register: hold until the sink takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_p1    <= p1;
            r_o_p2    <= p2;
            r_o_split <= r_split;
            if (r_below >= r_above) begin
                r_lower <= r_split;
                r_upper <= GRAY_MAX;
            end else begin
                r_lower <= '0;
                r_upper <= r_split;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.lower_bound = r_lower;
    assign o_res.upper_bound = r_upper;
    assign o_res.peak_one    = r_o_p1;
    assign o_res.peak_two    = r_o_p2;
    assign o_res.split_level = r_o_split;

    assign o_sts.busy     = r_c_valid || r_s1_valid || r_s2_valid || r_s3_valid || r_q_valid;
    assign o_sts.out_full = r_out_valid;
    assign o_sts.last_acc = pix_acc && i_pix.frame_last;
    assign o_sts.p_lo     = (p1 < p2) ? p1 : p2;
    assign o_sts.p_hi     = (p1 < p2) ? p2 : p1;
endmodule
`default_nettype wire

// ===== src/bht_ctrl.sv =====
// Controller: sequences bin clearing, pixel collection and the per-frame passes.
// Depends on bht_pkg and the assertion macro header.
`default_nettype none
`include "bimodal_histogram_threshold_core_macros.svh"
module bht_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bht_pkg::t_cfg    i_cfg,
    input  wire bht_pkg::t_dp_sts i_sts,
    output bht_pkg::t_dp_cmd      o_cmd
);
    import bht_pkg::*;

    typedef enum logic [13:0] {
        ST_CLEAR   = 14'b00000000000001,
        ST_COLLECT = 14'b00000000000010,
        ST_FLUSH   = 14'b00000000000100,
        ST_SMOOTH  = 14'b00000000001000,
        ST_SDRAIN  = 14'b00000000010000,
        ST_PEAK2   = 14'b00000000100000,
        ST_PDRAIN  = 14'b00000001000000,
        ST_SPLIT   = 14'b00000010000000,
        ST_VINIT   = 14'b00000100000000,
        ST_VSCAN   = 14'b00001000000000,
        ST_VDRAIN  = 14'b00010000000000,
        ST_WEIGH   = 14'b00100000000000,
        ST_WDRAIN  = 14'b01000000000000,
        ST_RESULT  = 14'b10000000000000
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [PK_W-1:0] r_cnt;
    logic [PK_W-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.op   = OP_NONE;
        o_cmd.addr = r_cnt;
        case (r_state)
            // sweep zeros through the bins after reset
            ST_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                n_cnt    = r_cnt + PK_W'(1);
                if (r_cnt == BIN_END - PK_W'(1)) begin
                    n_state = ST_COLLECT;
                end
            end
            ST_COLLECT: begin
                o_cmd.pix_en = 1'b1;
                if (i_sts.last_acc) begin
                    n_state = ST_FLUSH;
                end
            end
            // let the last pixel's write land
            ST_FLUSH: begin
                o_cmd.init = 1'b1;
                n_cnt      = '0;
                n_state    = ST_SMOOTH;
            end
            // one extra step past the top bin closes the window
            ST_SMOOTH: begin
                o_cmd.op = OP_SMOOTH;
                n_cnt    = r_cnt + PK_W'(1);
                if (r_cnt == BIN_END) begin
                    n_state = ST_SDRAIN;
                end
            end
            ST_SDRAIN: begin
                n_cnt = '0;
                if (!i_sts.busy) begin
                    n_state = ST_PEAK2;
                end
            end
            ST_PEAK2: begin
                o_cmd.op = OP_PEAK2;
                n_cnt    = r_cnt + PK_W'(1);
                if (r_cnt == BIN_END - PK_W'(1)) begin
                    n_state = ST_PDRAIN;
                end
            end
            ST_PDRAIN: begin
                if (!i_sts.busy) begin
                    n_state = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                n_cnt = '0;
                if (i_cfg.tech == TECH_MID) begin
                    o_cmd.set_mid = 1'b1;
                    n_state       = ST_WEIGH;
                end else begin
                    n_state = ST_VINIT;
                end
            end
            // valley starts just above the lower peak, indices wrap at 8 bits
            ST_VINIT: begin
                o_cmd.op   = OP_VINIT;
                o_cmd.addr = {1'b0, i_sts.p_lo + 8'd1};
                n_cnt      = {1'b0, i_sts.p_lo + 8'd2};
                n_state    = ST_VSCAN;
            end
            ST_VSCAN: begin
                if (r_cnt < {1'b0, i_sts.p_hi}) begin
                    o_cmd.op = OP_VSCAN;
                    n_cnt    = r_cnt + PK_W'(1);
                end else begin
                    n_state = ST_VDRAIN;
                end
            end
            ST_VDRAIN: begin
                n_cnt = '0;
                if (!i_sts.busy) begin
                    o_cmd.set_valley = 1'b1;
                    n_state          = ST_WEIGH;
                end
            end
            ST_WEIGH: begin
                o_cmd.op = OP_WEIGH;
                n_cnt    = r_cnt + PK_W'(1);
                if (r_cnt == BIN_END - PK_W'(1)) begin
                    n_state = ST_WDRAIN;
                end
            end
            ST_WDRAIN: begin
                if (!i_sts.busy) begin
                    n_state = ST_RESULT;
                end
            end
            // wait for the result register to empty
            ST_RESULT: begin
                if (!i_sts.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `BHT_ASSERT_NEXT(a_last_stops_collect, i_sts.last_acc, r_state == ST_FLUSH)
    `BHT_ASSERT_NOW(a_load_needs_space, o_cmd.load_out, !i_sts.out_full && !i_sts.busy)
    `BHT_ASSERT_NEXT(a_smooth_ends, (r_state == ST_SMOOTH) && (r_cnt == BIN_END),
                     r_state == ST_SDRAIN)
    `BHT_ASSERT_NOW(a_split_after_drain, o_cmd.set_valley || o_cmd.set_mid, !i_sts.busy)
endmodule
`default_nettype wire

// ===== src/bimodal_histogram_threshold_core.sv =====
// Top level of the bimodal histogram threshold core: APB registers, controller, datapath.
// Depends on bht_pkg, bht_if, bht_ctrl and bht_dp.
//
//  channel  | dir | beat contents
//  i_pix    | in  | gray_level, frame_last
//  o_res    | out | lower_bound, upper_bound, peak_one, peak_two, split_level
//  APB      | in  | technique (0x0), spacing (0x4)
//
// A pixel is taken every cycle while collecting; the bin update is a read-modify-write
// with forwarding of the previous write. After the last pixel the input is held off while
// the frame is evaluated, with either the midpoint split or the valley scan.
// After reset a clearing pass over all 256 bins runs before the first pixel is taken.
// The result waits in an output register; a full register stalls only the next frame end.
`default_nettype none
module bimodal_histogram_threshold_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    bht_pix_if.sink                   i_pix,
    bht_res_if.source                 o_res,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import bht_pkg::*;

    t_cfg    r_cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    wr_en;

    // register writes on the access phase
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tech  <= TECH_MID;
            r_cfg.space <= SPACING_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_TECH) begin
                r_cfg.tech <= pwdata[0];
            end else begin
                r_cfg.space <= pwdata[PIX_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SPACE) ? {24'd0, r_cfg.space} : {31'd0, r_cfg.tech};

    bht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bht_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_pix   (i_pix),
        .o_res   (o_res)
    );
endmodule
`default_nettype wire
